/* sv/assert_macros.svh */
// assertion macros used by spq_ctrl of the priority queue
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/spq_pkg.sv */
// shared types, constants and helpers of the stable priority queue
// no dependencies; used by spq_ctrl and stable_priority_queue
package spq_pkg;

  localparam int IdW    = 16;
  localparam int LvlW   = 2;
  localparam int EntryW = IdW + LvlW;
  localparam int OccW   = 5;

  localparam logic [LvlW-1:0] LvlVip = 2'd2;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  // one incoming request
  typedef struct packed {
    action_e           action;
    logic [IdW-1:0]    request_id;
    logic [LvlW-1:0]   level;
  } req_t;

  // one result
  typedef struct packed {
    logic              served_valid;
    logic [IdW-1:0]    served_id;
    logic [LvlW-1:0]   served_level;
    logic              empty_flag;
    logic              full_flag;
    logic [OccW-1:0]   occupancy;
  } res_t;

  // out-of-range level saturates to vip
  function automatic logic [LvlW-1:0] sat_level(input logic [LvlW-1:0] lvl);
    sat_level = (lvl > LvlVip) ? LvlVip : lvl;
  endfunction

endpackage

/* sv/spq_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies; holds the queue entries
module spq_ram #(
  parameter int Width = 18,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/spq_ctrl.sv */
// sequencer of the priority queue: walks the entry ram one entry a cycle
// depends on spq_pkg, spq_ram and assert_macros.svh
`include "assert_macros.svh"

module spq_ctrl #(
  parameter int Depth = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  spq_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output spq_pkg::res_t res_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_REM_HEAD,
    ST_REM_SHIFT,
    ST_RESP
  } state_e;

  state_e                          state_q, state_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   pos_q, pos_d;
  logic [spq_pkg::IdW-1:0]         id_q, id_d;
  logic [spq_pkg::LvlW-1:0]        lvl_q, lvl_d;
  spq_pkg::res_t                   res_q, res_d;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [AW-1:0]                   ram_raddr;
  logic [spq_pkg::EntryW-1:0]      ram_wdata;
  logic [spq_pkg::EntryW-1:0]      ram_rdata;
  logic [spq_pkg::LvlW-1:0]        rd_lvl;
  logic [spq_pkg::LvlW-1:0]        req_lvl;

  logic [CW-1:0] cnt_m1, cnt_p1, pos_m1, pos_m2, pos_p1;
  logic          store_full;

  assign rd_lvl     = ram_rdata[spq_pkg::EntryW-1:spq_pkg::IdW];
  assign req_lvl    = spq_pkg::sat_level(req_i.level);
  assign cnt_m1     = count_q - CW'(1);
  assign cnt_p1     = count_q + CW'(1);
  assign pos_m1     = pos_q - CW'(1);
  assign pos_m2     = pos_q - CW'(2);
  assign pos_p1     = pos_q + CW'(1);
  assign store_full = (count_q == CW'(Depth));

  // entry store
  spq_ram #(
    .Width(spq_pkg::EntryW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // sequencer: one compare and one ram move per cycle
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    id_d      = id_q;
    lvl_d     = lvl_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = {lvl_q, id_q};
    ram_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          id_d  = req_i.request_id;
          lvl_d = req_lvl;
          res_d = '0;
          if (req_i.action == spq_pkg::ACT_INSERT) begin
            if (store_full) begin
              res_d.full_flag = 1'b1;
              state_d         = ST_RESP;
            end else if (count_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = {req_lvl, req_i.request_id};
              count_d   = cnt_p1;
              state_d   = ST_RESP;
            end else begin
              ram_raddr = cnt_m1[AW-1:0];
              pos_d     = count_q;
              state_d   = ST_INS_CMP;
            end
          end else begin
            if (count_q == '0) begin
              res_d.empty_flag = 1'b1;
              state_d          = ST_RESP;
            end else begin
              ram_raddr = '0;
              state_d   = ST_REM_HEAD;
            end
          end
        end
      end
      ST_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        if (rd_lvl < lvl_q) begin
          // lower level entry moves back one place
          ram_wdata = ram_rdata;
          pos_d     = pos_m1;
          if (pos_q == CW'(1)) begin
            state_d = ST_INS_PUT;
          end else begin
            ram_raddr = pos_m2[AW-1:0];
          end
        end else begin
          count_d = cnt_p1;
          state_d = ST_RESP;
        end
      end
      ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        count_d   = cnt_p1;
        state_d   = ST_RESP;
      end
      ST_REM_HEAD: begin
        res_d.served_valid = 1'b1;
        res_d.served_id    = ram_rdata[spq_pkg::IdW-1:0];
        res_d.served_level = rd_lvl;
        if (count_q == CW'(1)) begin
          count_d = cnt_m1;
          state_d = ST_RESP;
        end else begin
          ram_raddr = AW'(1);
          pos_d     = CW'(1);
          state_d   = ST_REM_SHIFT;
        end
      end
      ST_REM_SHIFT: begin
        // pull each remaining entry forward by one
        ram_we    = 1'b1;
        ram_waddr = pos_m1[AW-1:0];
        ram_wdata = ram_rdata;
        if (pos_p1 < count_q) begin
          ram_raddr = pos_p1[AW-1:0];
          pos_d     = pos_p1;
        end else begin
          count_d = cnt_m1;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state, count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    lvl_q <= lvl_d;
    res_q <= res_d;
  end

  // handshakes and result
  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);

  always_comb begin
    res_o           = res_q;
    res_o.occupancy = spq_pkg::OccW'(count_q);
  end

  // checks
  `SPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(Depth),
              "entry count above queue depth")
  `SPQ_ASSERT(a_write_region, clk_i, rst_ni, ram_we |-> (CW'(ram_waddr) <= count_q),
              "ram write beyond held entries")
  `SPQ_ASSERT(a_full_result, clk_i, rst_ni,
              (state_q == ST_RESP && res_q.full_flag) |-> store_full,
              "full reported while store has room")
  `SPQ_ASSERT_NEXT(a_leave_idle, clk_i, rst_ni, req_valid_i && req_ready_o,
                   state_q != ST_IDLE, "accepted request did not start")
  `SPQ_ASSERT(a_count_step, clk_i, rst_ni,
              count_q == $past(count_q) || count_q == $past(count_q) + CW'(1) ||
              count_q == $past(count_q) - CW'(1),
              "entry count moved by more than one")

endmodule

/* sv/stable_priority_queue.sv */
// top level of the stable three-level priority queue with output register
// depends on spq_pkg, spq_ctrl (which holds spq_ram)
//
//  channel  dir  handshake             payload
//  s_axis   in   s_axis_tvalid/tready  tdata: request_id, level; tuser: action
//  m_axis   out  m_axis_tvalid/tready  tdata: served_id, served_level, occupancy;
//                                      tuser: served_valid, empty_flag, full_flag
//
// one request at a time; entries move through the entry ram one per cycle
// insert if not full: lower levels move back a place, then the new entry is written
// remove if not empty: the head is served and each other entry moves up a place
// the next request is taken while the previous result waits in the output register
// reset clears the entry count and sequencer; ram contents are never cleared
// a stalled m_axis holds its result and blocks the sequencer at its response step
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] request_id, [17:16] level, zero pad
  input  logic [0:0]  s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] served_id, [17:16] served_level,
                                     // [22:18] occupancy, zero pad
  output logic [2:0]  m_axis_tuser   // [0] served_valid, [1] empty_flag, [2] full_flag
);

  spq_pkg::req_t req;
  spq_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;

  logic          out_valid_q, out_valid_d;
  spq_pkg::res_t out_q;

  // unpack request
  assign req.action     = spq_pkg::action_e'(s_axis_tuser[0]);
  assign req.request_id = s_axis_tdata[15:0];
  assign req.level      = s_axis_tdata[17:16];

  spq_ctrl #(
    .Depth(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // pack result
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.occupancy, out_q.served_level, out_q.served_id};
  assign m_axis_tuser  = {out_q.full_flag, out_q.empty_flag, out_q.served_valid};

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for stable_priority_queue: stream driver, monitor, in-order predictor
// depends on spq_pkg and the stable_priority_queue rtl
module tb;

  localparam int Depth     = 16;
  localparam int RandItems = 1100;

  // one pending request, optionally held back until every result is back
  typedef struct {
    spq_pkg::req_t req;
    bit            drain;
  } stim_t;

  typedef struct packed {
    logic [spq_pkg::IdW-1:0]  id;
    logic [spq_pkg::LvlW-1:0] lvl;
  } slot_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [15:0] request_id, [17:16] level, zero pad
  logic [0:0]  s_axis_tuser = '0;  // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // [15:0] served_id, [17:16] served_level, [22:18] occupancy
  logic [2:0]  m_axis_tuser;  // [0] served_valid, [1] empty_flag, [2] full_flag

  stim_t         pending_q[$];
  spq_pkg::res_t served_q[$];

  // predictor state: entries in service order, front at index 0
  slot_t line_slots[Depth];
  int    line_count = 0;

  spq_pkg::req_t cur_req;
  int    snd_wait = 0;
  bit    snd_calm = 1'b0;
  int    sent_cnt = 0;
  int    rcv_wait = 0;
  bit    rcv_calm = 1'b0;
  int    rcv_cnt = 0;
  int    err_cnt = 0;

  stable_priority_queue #(.QUEUE_DEPTH(Depth)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // advance the queue model by one request and return the result it should give
  function automatic spq_pkg::res_t serve_request(spq_pkg::req_t r);
    spq_pkg::res_t            rs;
    logic [spq_pkg::LvlW-1:0] lvl;
    int                       pos;
    rs = '0;
    lvl = (r.level > 2'd2) ? 2'd2 : r.level;
    if (r.action == spq_pkg::ACT_INSERT) begin
      if (line_count >= Depth) begin
        rs.full_flag = 1'b1;
      end else begin
        // walk past lower levels so equal levels keep arrival order
        pos = line_count;
        while (pos > 0 && line_slots[pos-1].lvl < lvl) begin
          line_slots[pos] = line_slots[pos-1];
          pos--;
        end
        line_slots[pos] = '{id: r.request_id, lvl: lvl};
        line_count++;
      end
    end else begin
      if (line_count == 0) begin
        rs.empty_flag = 1'b1;
      end else begin
        rs.served_valid = 1'b1;
        rs.served_id    = line_slots[0].id;
        rs.served_level = line_slots[0].lvl;
        for (int i = 1; i < line_count; i++) line_slots[i-1] = line_slots[i];
        line_count--;
      end
    end
    rs.occupancy = line_count[spq_pkg::OccW-1:0];
    return rs;
  endfunction

  task automatic add_req(spq_pkg::action_e act, logic [spq_pkg::IdW-1:0] id,
                         logic [spq_pkg::LvlW-1:0] lvl, bit drain);
    stim_t s;
    s.req.action     = act;
    s.req.request_id = id;
    s.req.level      = lvl;
    s.drain          = drain;
    pending_q.push_back(s);
  endtask

  task automatic log_mismatch(string what);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", what);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        served_q.push_back(serve_request(cur_req));
        snd_wait = snd_calm ? 0 : $urandom_range(0, 4);
        sent_cnt++;
        if (sent_cnt % 64 == 0) snd_calm = ($urandom_range(0, 3) == 0);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (snd_wait > 0) begin
          snd_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     (!pending_q[0].drain || served_q.size() == 0)) begin
          cur_req = pending_q[0].req;
          void'(pending_q.pop_front());
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, cur_req.level, cur_req.request_id};
          s_axis_tuser  <= cur_req.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    spq_pkg::res_t got;
    spq_pkg::res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.served_valid = m_axis_tuser[0];
        got.empty_flag   = m_axis_tuser[1];
        got.full_flag    = m_axis_tuser[2];
        got.served_id    = m_axis_tdata[15:0];
        got.served_level = m_axis_tdata[17:16];
        got.occupancy    = m_axis_tdata[22:18];
        if (served_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result id=%h lvl=%0d occ=%0d",
                                 got.served_id, got.served_level, got.occupancy));
        end else begin
          want = served_q.pop_front();
          if (got !== want)
            log_mismatch($sformatf({"result %0d: exp v=%b id=%h lvl=%0d e=%b f=%b occ=%0d",
                                    " got v=%b id=%h lvl=%0d e=%b f=%b occ=%0d"}, rcv_cnt,
                                   want.served_valid, want.served_id, want.served_level,
                                   want.empty_flag, want.full_flag, want.occupancy,
                                   got.served_valid, got.served_id, got.served_level,
                                   got.empty_flag, got.full_flag, got.occupancy));
        end
        rcv_cnt++;
        rcv_wait = rcv_calm ? 0 : $urandom_range(0, 4);
        if (rcv_cnt % 50 == 0) rcv_calm = ($urandom_range(0, 3) == 0);
      end
      if (rcv_wait > 0) begin
        rcv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int ins_pct;
    int r;
    logic [spq_pkg::LvlW-1:0] lvl;

    // directed: empty remove, id and level extremes, fill to full, reject, serve
    add_req(spq_pkg::ACT_REMOVE, 16'h0000, 2'd0, 1'b0);
    add_req(spq_pkg::ACT_INSERT, 16'h0000, 2'd0, 1'b0);
    add_req(spq_pkg::ACT_INSERT, 16'hFFFF, 2'd3, 1'b0);
    add_req(spq_pkg::ACT_INSERT, 16'h1234, 2'd1, 1'b0);
    add_req(spq_pkg::ACT_INSERT, 16'h00FF, 2'd2, 1'b0);
    add_req(spq_pkg::ACT_INSERT, 16'hFF00, 2'd0, 1'b0);
    for (int i = 0; i < 10; i++)
      add_req(spq_pkg::ACT_INSERT, 16'(16'h0100 + i), 2'(i % 4), 1'b0);
    add_req(spq_pkg::ACT_INSERT, 16'hA5A5, 2'd1, 1'b0);
    add_req(spq_pkg::ACT_INSERT, 16'h5A5A, 2'd2, 1'b0);
    for (int i = 0; i < 4; i++)
      add_req(spq_pkg::ACT_REMOVE, 16'hFFFF, 2'd3, 1'b0);
    add_req(spq_pkg::ACT_INSERT, 16'hC3C3, 2'd3, 1'b0);

    // random: phases of insert-heavy and remove-heavy traffic sweep full and empty
    ins_pct = 50;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: ins_pct = 25;
          1: ins_pct = 50;
          2: ins_pct = 75;
          default: ins_pct = 90;
        endcase
      end
      r = $urandom_range(0, 9);
      lvl = (r < 3) ? 2'd0 : (r < 6) ? 2'd1 : (r < 9) ? 2'd2 : 2'd3;
      add_req(($urandom_range(0, 99) < ins_pct) ? spq_pkg::ACT_INSERT : spq_pkg::ACT_REMOVE,
              16'($urandom_range(0, 65535)), lvl, (n == 0) || (n == RandItems / 2));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (served_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (err_cnt == 0 && served_q.size() == 0) begin
      $display("[stable_priority_queue] OK");
    end else begin
      $display("[stable_priority_queue] ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #3ms;
    $display("[stable_priority_queue] ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/spq_pkg.sv
sv/spq_ram.sv
sv/spq_ctrl.sv
sv/stable_priority_queue.sv
sim/tb.sv
